/* design/afef_pkg.sv */
// Package for the audio frame energy fingerprint block.
// Holds sizes, command and register codes, the result record and the header
// byte table. No dependencies.
package afef_pkg;

  localparam int FRAME_LEN = 256;
  localparam int HOP_LEN   = 128;
  localparam int HOP_BITS  = $clog2(HOP_LEN);
  localparam int FNUM_W    = 32 - HOP_BITS;
  localparam int HALF_W    = 22;

  localparam logic [31:0] DEFAULT_RATE = 32'd16000;

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic REG_RATE_HZ       = 1'b0;
  localparam logic REG_TOTAL_SAMPLES = 1'b1;

  localparam logic [3:0] HDR_LAST   = 4'd15;
  localparam logic [3:0] FRAME_LAST = 4'd1;

  localparam logic [7:0] MAGIC_A   = 8'h41;
  localparam logic [7:0] MAGIC_C   = 8'h43;
  localparam logic [7:0] MAGIC_R   = 8'h52;
  localparam logic [7:0] MAGIC_1   = 8'h31;
  localparam logic [7:0] VERSION   = 8'd1;
  localparam logic [7:0] CHANNELS  = 8'd1;

  // one pending result: either the 16-byte header or a 2-byte frame hash
  typedef struct packed {
    logic        is_header;
    logic [31:0] rate;
    logic [31:0] count;
    logic        last;
    logic [15:0] hash;
    logic        fin;
  } afef_rec_t;

  function automatic logic [7:0] hdr_byte(input logic [3:0] idx,
                                          input logic [31:0] rate,
                                          input logic [31:0] cnt);
    logic [7:0] b;
    case (idx)
      4'd0:    b = MAGIC_A;
      4'd1:    b = MAGIC_C;
      4'd2:    b = MAGIC_R;
      4'd3:    b = MAGIC_1;
      4'd4:    b = VERSION;
      4'd5:    b = 8'd0;
      4'd6:    b = CHANNELS;
      4'd7:    b = 8'd0;
      4'd8:    b = rate[7:0];
      4'd9:    b = rate[15:8];
      4'd10:   b = rate[23:16];
      4'd11:   b = rate[31:24];
      4'd12:   b = cnt[7:0];
      4'd13:   b = cnt[15:8];
      4'd14:   b = cnt[23:16];
      4'd15:   b = cnt[31:24];
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

/* design/afef_if.sv */
// Stream interfaces of the fingerprint block: sample input and byte output.
// Valid/ready handshake; no dependencies.
interface afef_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [15:0] pcm_sample;

  modport source (output valid, output cmd, output pcm_sample, input ready);
  modport sink   (input valid, input cmd, input pcm_sample, output ready);
endinterface

interface afef_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       final_byte;

  modport source (output valid, output out_byte, output final_byte, input ready);
  modport sink   (input valid, input out_byte, input final_byte, output ready);
endinterface

/* design/audio_frame_energy_fingerprint_unit.sv */
// Audio frame energy fingerprint: header on start, 2-byte hash per frame.
// Latency: first result byte is offered the cycle after the item is taken.
// Throughput: one transaction per cycle; only a start or a frame-closing sample
// waits on pending bytes, until the last byte of the held header or frame hash is taken.
// Reset (rst, synchronous, active high): rate 16000, count 0, not started.
// Depends on afef_pkg, afef_if and afef_serializer.
module audio_frame_energy_fingerprint_unit (
  input  logic        clk,
  input  logic        rst,
  afef_in_if.sink     in_chan,
  afef_out_if.source  out_chan,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import afef_pkg::*;

  logic [30:0]       rate_hz;
  logic [31:0]       total_samples;
  logic [31:0]       sample_index;
  logic [HALF_W-1:0] half_energy;
  logic [HALF_W-1:0] previous_half_energy;
  logic [FNUM_W-1:0] frame_number;
  logic              started;

  logic               in_take;
  logic               ser_free;
  logic               ser_load;
  logic               needs_ser;
  afef_rec_t          rec_next;
  logic [31:0]        tot_minus;
  logic [FNUM_W-1:0]  frames_total;
  logic               sample_ok;
  logic signed [31:0] prod;
  logic [14:0]        sq;
  logic [HALF_W-1:0]  half_sum;
  logic [31:0]        idx_next;
  logic               hop_end;
  logic               emit_frame;
  logic [15:0]        energy;
  logic [31:0]        offset_full;

  // only a transaction that produces bytes has to wait for the serializer
  assign in_chan.ready = ser_free || !needs_ser;
  assign in_take       = in_chan.valid && in_chan.ready;

  assign tot_minus    = total_samples - 32'(FRAME_LEN);
  assign frames_total = (total_samples >= 32'(FRAME_LEN)) ?
                        FNUM_W'(tot_minus >> HOP_BITS) : '0;
  assign sample_ok    = started && (sample_index < total_samples);

  // square is non-negative and at most 2^30
  assign prod     = in_chan.pcm_sample * in_chan.pcm_sample;
  assign sq       = prod[30:16];
  assign half_sum = half_energy + HALF_W'(sq);
  assign idx_next = sample_index + 32'd1;
  assign hop_end  = (idx_next[HOP_BITS-1:0] == '0);

  assign emit_frame = hop_end && (idx_next >= 32'(FRAME_LEN)) &&
                      (frame_number < frames_total);

  assign energy      = previous_half_energy[15:0] + half_sum[15:0];
  assign offset_full = {frame_number, {HOP_BITS{1'b0}}};

  always_comb begin
    rec_next.is_header = (in_chan.cmd == CMD_START);
    rec_next.rate      = (rate_hz == '0) ? DEFAULT_RATE : {1'b0, rate_hz};
    rec_next.count     = total_samples;
    rec_next.last      = (frames_total == '0);
    rec_next.hash      = energy ^ offset_full[15:0];
    rec_next.fin       = ((frame_number + FNUM_W'(1)) == frames_total);
  end

  assign needs_ser = (in_chan.cmd == CMD_START) || (sample_ok && emit_frame);
  assign ser_load  = in_take && needs_ser;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_hz       <= 31'(DEFAULT_RATE);
      total_samples <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RATE_HZ:       rate_hz       <= cfg_data[30:0];
        REG_TOTAL_SAMPLES: total_samples <= cfg_data;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index         <= '0;
      half_energy          <= '0;
      previous_half_energy <= '0;
      frame_number         <= '0;
      started              <= 1'b0;
    end else if (in_take) begin
      if (in_chan.cmd == CMD_START) begin
        sample_index         <= '0;
        half_energy          <= '0;
        previous_half_energy <= '0;
        frame_number         <= '0;
        started              <= 1'b1;
      end else if (sample_ok) begin
        sample_index <= idx_next;
        if (hop_end) begin
          previous_half_energy <= half_sum;
          half_energy          <= '0;
          if (emit_frame) begin
            frame_number <= frame_number + FNUM_W'(1);
          end
        end else begin
          half_energy <= half_sum;
        end
      end
    end
  end

  afef_serializer u_ser (
    .clk      (clk),
    .rst      (rst),
    .load     (ser_load),
    .rec_in   (rec_next),
    .free     (ser_free),
    .out_chan (out_chan)
  );

`ifndef SYNTHESIS
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (in_take && in_chan.cmd == CMD_START) |=>
    (started && sample_index == '0 && frame_number == '0))
    else $error("start did not clear running state");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (in_take && in_chan.cmd == CMD_SAMPLE && !sample_ok) |=> $stable(sample_index))
    else $error("ignored sample advanced the index");
  a_frame_bound: assert property (@(posedge clk) disable iff (rst)
    (ser_load && in_chan.cmd == CMD_SAMPLE) |-> (frame_number < frames_total))
    else $error("frame emitted beyond frame count");
`endif

endmodule

/* design/afef_serializer.sv */
// Byte serializer: holds one result record and sends it out a byte per
// transaction. Depends on afef_pkg and afef_out_if.
module afef_serializer (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  afef_pkg::afef_rec_t rec_in,
  output logic                free,
  afef_out_if.source          out_chan
);
  import afef_pkg::*;

  logic      valid;
  logic [3:0] idx;
  afef_rec_t rec;
  logic [3:0] last_idx;
  logic      take;
  logic      done;

  assign last_idx = rec.is_header ? HDR_LAST : FRAME_LAST;
  assign take     = valid && out_chan.ready;
  assign done     = take && (idx == last_idx);
  assign free     = !valid || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (take) begin
      if (done) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec <= rec_in;
    end
  end

  assign out_chan.valid = valid;

  always_comb begin
    if (rec.is_header) begin
      out_chan.out_byte   = hdr_byte(idx, rec.rate, rec.count);
      out_chan.final_byte = (idx == HDR_LAST) && rec.last;
    end else begin
      out_chan.out_byte   = idx[0] ? rec.hash[15:8] : rec.hash[7:0];
      out_chan.final_byte = idx[0] && rec.fin;
    end
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst) load |-> free)
    else $error("record loaded while bytes still pending");
  a_final_last: assert property (@(posedge clk) disable iff (rst)
    (valid && out_chan.final_byte) |-> (idx == last_idx))
    else $error("final flag before last byte of record");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (valid && !out_chan.ready && !load) |=> (valid && $stable(idx)))
    else $error("byte index moved while stalled");
`endif

endmodule
